FILE: hdl/spsq_pkg.sv
`default_nettype none
package spsq_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int DATA_W           = 32;
   localparam int PRIO_W           = 32;
   localparam int OCC_W            = 5;

   typedef enum logic {
      CMD_ENQ = 1'b0,
      CMD_DEQ = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_ENQUEUED = 2'd0,
      STATUS_DEQUEUED = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
   } entry_type;

   // broadcast to every cell in the chain
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage
`default_nettype wire

FILE: hdl/spsq_if.sv
`default_nettype none
interface spsq_req_if
   import spsq_pkg::*;
();
   logic                     valid;
   logic                     ready;
   cmd_type                  cmd;
   logic signed [DATA_W-1:0] data_value;
   logic signed [PRIO_W-1:0] priority_req;

   modport source (output valid, output cmd, output data_value, output priority_req,
                   input ready);
   modport sink   (input valid, input cmd, input data_value, input priority_req,
                   output ready);
endinterface

interface spsq_rsp_if
   import spsq_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] out_data;
   status_type               status;
   logic [OCC_W-1:0]         occupancy;

   modport source (output valid, output out_data, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input out_data, input status, input occupancy,
                   output ready);
endinterface
`default_nettype wire

FILE: hdl/spsq_cell.sv
`default_nettype none
module spsq_cell
   import spsq_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          occupied,
   input  wire logic          left_keep,
   input  wire entry_type     left_entry,
   input  wire entry_type     right_entry,
   output      entry_type     entry,
   output      logic          keep
);

   entry_type entry_ff;
   entry_type entry_in;

   // entry stays in place on an enqueue if it is not after the new one
   assign keep  = occupied && (entry_ff.prio <= ctrl.new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.enq) begin
         if (!left_keep) begin
            entry_in = left_entry;
         end else if (!keep) begin
            entry_in = ctrl.new_entry;
         end
      end else if (ctrl.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

FILE: hdl/stable_sorted_priority_queue_core.sv
// Response: a result appears in the cycle after its request transfer.
// Throughput: 1 operation per cycle; every cell of the chain compares and
// shifts in the same cycle, and the response register frees each cycle it drains.
// Reset: synchronous; clears the entry count and the response valid. Cell
// contents are not reset and are only read below the entry count.
`default_nettype none
module stable_sorted_priority_queue_core
   import spsq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   spsq_req_if.sink   req_bus,
   spsq_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0] rsp_occ_ff, rsp_occ_in;

   logic          accept, full, empty;
   cell_ctrl_type ctrl;
   entry_type     cell_entry [CAPACITY];
   logic          cell_keep  [CAPACITY];

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign full          = (count_ff == CNT_W'(CAPACITY));
   assign empty         = (count_ff == '0);

   assign ctrl.enq            = accept && (req_bus.cmd == CMD_ENQ) && !full;
   assign ctrl.deq            = accept && (req_bus.cmd == CMD_DEQ) && !empty;
   assign ctrl.new_entry.data = req_bus.data_value;
   assign ctrl.new_entry.prio = req_bus.priority_req;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      occupied, left_keep;
      entry_type left_entry, right_entry;

      assign occupied = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_keep  = 1'b1;
         assign left_entry = ctrl.new_entry;
      end else begin : g_body
         assign left_keep  = cell_keep[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spsq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied),
         .left_keep   (left_keep),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .keep        (cell_keep[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         unique case (req_bus.cmd)
            CMD_ENQ: begin
               if (full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  rsp_status_in = STATUS_ENQUEUED;
                  count_in      = count_ff + 1'b1;
               end
            end
            CMD_DEQ: begin
               if (empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  rsp_status_in = STATUS_DEQUEUED;
                  rsp_data_in   = cell_entry[0].data;
                  count_in      = count_ff - 1'b1;
               end
            end
            default: begin
               rsp_status_in = STATUS_EMPTY;
            end
         endcase
         rsp_occ_in = OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_data  = rsp_data_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.occupancy = rsp_occ_ff;

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import spsq_pkg::*;

   localparam int CAP            = CAPACITY_DEFAULT;
   localparam int ITEMS_PER_PASS = 325;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 8;

   typedef struct {
      logic signed [DATA_W-1:0] data;
      status_type               status;
      logic [OCC_W-1:0]         occupancy;
   } pq_outcome_type;

   class pq_scoreboard;
      logic signed [DATA_W-1:0] slot_val [CAP];
      logic signed [PRIO_W-1:0] slot_rank [CAP];
      int                       held;
      pq_outcome_type           expected_q[$];
      int                       mismatches;
      int                       n_enq, n_deq, n_empty, n_full, n_checked;

      function new();
         held       = 0;
         mismatches = 0;
         n_enq      = 0;
         n_deq      = 0;
         n_empty    = 0;
         n_full     = 0;
         n_checked  = 0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH: %s", msg);
      endfunction

      // sorted insert after all entries of equal or smaller priority, pop from front
      function void note_request(cmd_type cmd, logic signed [DATA_W-1:0] data,
                                 logic signed [PRIO_W-1:0] prio);
         pq_outcome_type o;
         int             pos;
         o.data = '0;
         if (cmd == CMD_ENQ) begin
            if (held >= CAP) begin
               o.status = STATUS_FULL;
               n_full++;
            end else begin
               pos = 0;
               while (pos < held && slot_rank[pos] <= prio) pos++;
               for (int i = held; i > pos; i--) begin
                  slot_val[i]  = slot_val[i-1];
                  slot_rank[i] = slot_rank[i-1];
               end
               slot_val[pos]  = data;
               slot_rank[pos] = prio;
               held++;
               o.status = STATUS_ENQUEUED;
               n_enq++;
            end
         end else begin
            if (held == 0) begin
               o.status = STATUS_EMPTY;
               n_empty++;
            end else begin
               o.data = slot_val[0];
               for (int i = 1; i < held; i++) begin
                  slot_val[i-1]  = slot_val[i];
                  slot_rank[i-1] = slot_rank[i];
               end
               held--;
               o.status = STATUS_DEQUEUED;
               n_deq++;
            end
         end
         o.occupancy = OCC_W'(held);
         expected_q.push_back(o);
      endfunction

      function void check_response(logic signed [DATA_W-1:0] data, status_type status,
                                   logic [OCC_W-1:0] occ);
         pq_outcome_type o;
         if (expected_q.size() == 0) begin
            flag($sformatf("response with nothing pending: data=%0d status=%s occ=%0d",
                           data, status.name(), occ));
            return;
         end
         o = expected_q.pop_front();
         n_checked++;
         if (data !== o.data || status !== o.status || occ !== o.occupancy)
            flag($sformatf({"response %0d: expected data=%0d status=%s occ=%0d, ",
                            "got data=%0d status=%s occ=%0d"},
                           n_checked, o.data, o.status.name(), o.occupancy,
                           data, status.name(), occ));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   idle_pct  = 0;
   int   stall_pct = 0;
   int   quiet_cycles;

   pq_scoreboard sb;

   spsq_req_if req ();
   spsq_rsp_if rsp ();

   stable_sorted_priority_queue_core #(
      .CAPACITY (CAP)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   // transfer monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req.valid && req.ready)
            sb.note_request(req.cmd, req.data_value, req.priority_req);
         if (rsp.valid && rsp.ready)
            sb.check_response(rsp.out_data, rsp.status, rsp.occupancy);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic send_op(cmd_type cmd, logic signed [DATA_W-1:0] data,
                          logic signed [PRIO_W-1:0] prio);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid        <= 1'b1;
      req.cmd          <= cmd;
      req.data_value   <= data;
      req.priority_req <= prio;
      do @(posedge clock); while (!req.ready);
   endtask

   // mostly narrow ranges so that ties are frequent
   function automatic logic signed [PRIO_W-1:0] pick_prio();
      logic signed [PRIO_W-1:0] p;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: p = $urandom_range(7);
         5, 6:          p = $signed($urandom_range(8)) - 4;
         7:             p = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default:       p = $urandom;
      endcase
      return p;
   endfunction

   logic signed [PRIO_W-1:0] dir_prio [16] = '{
      5, 5, 32'h7FFF_FFFF, 32'h8000_0000, 0, -1, 5, 3,
      3, -2, 7, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 5};
   logic signed [DATA_W-1:0] dir_data [16] = '{
      1, 2, 32'h7FFF_FFFF, 32'h8000_0000, 0, -1, 3, 10,
      11, 12, 13, 14, 15, 16, 17, 4};

   initial begin
      int enq_bias;
      sb               = new();
      reset            = 1'b1;
      req.valid        = 1'b0;
      req.cmd          = CMD_ENQ;
      req.data_value   = '0;
      req.priority_req = '0;
      rsp.ready        = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: empty pop, fill with extremes and ties, push when full, partial drain
      send_op(CMD_DEQ, $urandom, $urandom);
      for (int i = 0; i < 16; i++) send_op(CMD_ENQ, dir_data[i], dir_prio[i]);
      send_op(CMD_ENQ, $urandom, 0);
      repeat (7) send_op(CMD_DEQ, $urandom, $urandom);

      // random passes: none, sender gaps, receiver stalls, both
      enq_bias = 50;
      for (int pass = 0; pass < 4; pass++) begin
         case (pass)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 70; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 70; end
            default: begin idle_pct = 15; stall_pct = 15; end
         endcase
         for (int n = 0; n < ITEMS_PER_PASS; n++) begin
            // drift between filling and draining so full and empty both recur
            if (n % 40 == 0)
               case ($urandom_range(2))
                  0:       enq_bias = 20;
                  1:       enq_bias = 50;
                  default: enq_bias = 80;
               endcase
            if ($urandom_range(99) < enq_bias)
               send_op(CMD_ENQ, $urandom, pick_prio());
            else
               send_op(CMD_DEQ, $urandom, $urandom);
         end
      end
      @(negedge clock) req.valid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d operations: %0d enqueued, %0d dequeued, %0d empty pops, %0d full pushes",
               sb.n_enq + sb.n_deq + sb.n_empty + sb.n_full,
               sb.n_enq, sb.n_deq, sb.n_empty, sb.n_full);
      $display("Checked %0d responses, %0d mismatches, %0d still pending",
               sb.n_checked, sb.mismatches, sb.expected_q.size());
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/spsq_pkg.sv
hdl/spsq_if.sv
hdl/spsq_cell.sv
hdl/stable_sorted_priority_queue_core.sv
bench/tb_top.sv
